FILE: hw/rtl/spq_pkg.sv
// Shared sizes, command codes and the per-beat operation bundle for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OCC_W  = 5;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	// operation broadcast to every cell in the chain
	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic [DATA_W-1:0]        data;
		logic signed [PRIO_W-1:0] prio;
	} spq_op_t;

endpackage

FILE: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue: a chain of slot cells, head at cell zero, with a registered result.
//
// Request channel (req_valid / req_stall): command 0 enqueues data_in at
// priority_in, command 1 dequeues the head entry. Higher priority leaves
// first; equal priorities leave in arrival order.
// Response channel (rsp_valid / rsp_stall): exactly one beat per request,
// carrying data_out / data_valid for a dequeue, empty_error for a dequeue of
// an empty queue, full_error for a dropped enqueue, and occupancy after the
// operation.
// The response appears in the cycle after its request. Every cell compares and
// shifts in the same cycle, so one request is taken per cycle unless stalled;
// the single output register sets that rate and frees up when its beat is taken.
// While rsp_stall holds a pending response, req_stall is raised and the
// queue contents do not change.
// Reset empties the queue and clears rsp_valid; slot contents and response
// fields are not cleared, and stale values in unoccupied slots never reach a response.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     command,
	input  logic [DATA_W-1:0]        data_in,
	input  logic signed [PRIO_W-1:0] priority_in,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [DATA_W-1:0]        data_out,
	output logic                     data_valid,
	output logic                     empty_error,
	output logic                     full_error,
	output logic [OCC_W-1:0]         occupancy
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             rsp_valid_q;
	logic [DATA_W-1:0] data_out_q;
	logic             data_valid_q;
	logic             empty_error_q;
	logic             full_error_q;
	logic [OCC_W-1:0] occupancy_q;

	logic    accept;
	logic    is_deq;
	logic    is_full;
	logic    is_empty;
	spq_op_t op;

	logic                     cell_ge   [DEPTH];
	logic [DATA_W-1:0]        cell_data [DEPTH];
	logic signed [PRIO_W-1:0] cell_prio [DEPTH];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign is_deq    = (command == CMD_DEQ);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);

	always_comb begin
		op.enq  = accept && !is_deq && !is_full;
		op.deq  = accept && is_deq && !is_empty;
		op.data = data_in;
		op.prio = priority_in;
		if (op.enq) begin
			count_next = count_q + CNT_W'(1);
		end else if (op.deq) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     l_ge;
		logic [DATA_W-1:0]        l_data;
		logic signed [PRIO_W-1:0] l_prio;
		logic [DATA_W-1:0]        r_data;
		logic signed [PRIO_W-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_ge   = 1'b1;
			assign l_data = data_in;
			assign l_prio = priority_in;
		end else begin : g_body
			assign l_ge   = cell_ge[i-1];
			assign l_data = cell_data[i-1];
			assign l_prio = cell_prio[i-1];
		end

		// tail cell refills with its own value on a dequeue; it is unoccupied then
		if (i == DEPTH - 1) begin : g_tail
			assign r_data = cell_data[i];
			assign r_prio = cell_prio[i];
		end else begin : g_mid
			assign r_data = cell_data[i+1];
			assign r_prio = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occ        (count_q > CNT_W'(i)),
			.left_ge    (l_ge),
			.left_data  (l_data),
			.left_prio  (l_prio),
			.right_data (r_data),
			.right_prio (r_prio),
			.ge         (cell_ge[i]),
			.data       (cell_data[i]),
			.prio       (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q    <= op.deq ? cell_data[0] : '0;
			data_valid_q  <= op.deq;
			empty_error_q <= is_deq && is_empty;
			full_error_q  <= !is_deq && is_full;
			occupancy_q   <= OCC_W'(count_next);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign data_out    = data_out_q;
	assign data_valid  = data_valid_q;
	assign empty_error = empty_error_q;
	assign full_error  = full_error_q;
	assign occupancy   = occupancy_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_deq_hit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_deq && !is_empty |=> rsp_valid && data_valid
		&& occupancy == OCC_W'($past(count_q) - CNT_W'(1)))
		else $error("dequeue of occupied queue lost its entry");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && full_error |-> occupancy == OCC_W'(DEPTH) && !data_valid)
		else $error("full error with free slots");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && empty_error |-> occupancy == '0 && !data_valid && !full_error)
		else $error("empty error with stored entries");
`endif

endmodule

FILE: hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares and shifts with its neighbors.
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  spq_op_t                  op,
	input  logic                     occ,
	input  logic                     left_ge,
	input  logic [DATA_W-1:0]        left_data,
	input  logic signed [PRIO_W-1:0] left_prio,
	input  logic [DATA_W-1:0]        right_data,
	input  logic signed [PRIO_W-1:0] right_prio,
	output logic                     ge,
	output logic [DATA_W-1:0]        data,
	output logic signed [PRIO_W-1:0] prio
);

	logic [DATA_W-1:0]        data_q;
	logic signed [PRIO_W-1:0] prio_q;

	// entry stays ahead of the new item when its priority is >= the new one
	assign ge   = occ && (prio_q >= op.prio);
	assign data = data_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (op.enq && !ge) begin
			if (left_ge) begin
				data_q <= op.data;
				prio_q <= op.prio;
			end else begin
				data_q <= left_data;
				prio_q <= left_prio;
			end
		end else if (op.deq) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule

FILE: tb/spq_checker.sv
// Checker for the sorted priority queue: mirrors the queue and compares every response beat.
module spq_checker
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	input  logic                     req_stall,
	input  logic                     command,
	input  logic [DATA_W-1:0]        data_in,
	input  logic signed [PRIO_W-1:0] priority_in,
	input  logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  logic [DATA_W-1:0]        data_out,
	input  logic                     data_valid,
	input  logic                     empty_error,
	input  logic                     full_error,
	input  logic [OCC_W-1:0]         occupancy,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic              data_valid;
		logic              empty_error;
		logic              full_error;
		logic [OCC_W-1:0]  occupancy;
	} queue_result_t;

	// mirror of the queue, head at slot zero
	logic [DATA_W-1:0]        mirror_payload [DEPTH];
	logic signed [PRIO_W-1:0] mirror_prio    [DEPTH];
	int                       mirror_count;

	queue_result_t owed_responses [$];
	queue_result_t want, got;

	task automatic mirror_op(input cmd_t op, input logic [DATA_W-1:0] d,
		input logic signed [PRIO_W-1:0] p, output queue_result_t r);
		int slot;
		r = '0;
		if (op == CMD_ENQ) begin
			if (mirror_count >= DEPTH) begin
				r.full_error = 1'b1;
			end else begin
				// new entry goes behind every entry of greater or equal priority
				slot = 0;
				while (slot < mirror_count && mirror_prio[slot] >= p)
					slot++;
				for (int i = mirror_count; i > slot; i--) begin
					mirror_payload[i] = mirror_payload[i-1];
					mirror_prio[i]    = mirror_prio[i-1];
				end
				mirror_payload[slot] = d;
				mirror_prio[slot]    = p;
				mirror_count++;
			end
		end else if (mirror_count == 0) begin
			r.empty_error = 1'b1;
		end else begin
			r.data_out   = mirror_payload[0];
			r.data_valid = 1'b1;
			for (int i = 1; i < mirror_count; i++) begin
				mirror_payload[i-1] = mirror_payload[i];
				mirror_prio[i-1]    = mirror_prio[i];
			end
			mirror_count--;
		end
		r.occupancy = OCC_W'(mirror_count);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
		input logic [DATA_W-1:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
		end
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_count = 0;
			owed_responses.delete();
		end else begin
			// response retires before the new request is mirrored
			if (rsp_valid && !rsp_stall) begin
				if (owed_responses.size() == 0) begin
					mismatches++;
					$display("%0t: response beat with no request outstanding", $time);
				end else begin
					want = owed_responses[0];
					owed_responses.delete(0);
					check_field("data_out", want.data_out, data_out);
					check_field("data_valid", DATA_W'(want.data_valid), DATA_W'(data_valid));
					check_field("empty_error", DATA_W'(want.empty_error),
						DATA_W'(empty_error));
					check_field("full_error", DATA_W'(want.full_error), DATA_W'(full_error));
					check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(occupancy));
				end
			end
			if (req_valid && !req_stall) begin
				mirror_op(cmd_t'(command), data_in, priority_in, got);
				owed_responses.push_back(got);
			end
		end
		outstanding = owed_responses.size();
	end

endmodule

FILE: tb/tb_sorted_priority_queue.sv
// Testbench top for the sorted priority queue: clock, reset, request and response pacing, verdict.
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int RANDOM_OPS = 400;
	localparam int HOLD_CYCLES = 60;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	logic                     command;
	logic [DATA_W-1:0]        data_in;
	logic signed [PRIO_W-1:0] priority_in;
	logic                     rsp_valid;
	logic                     rsp_stall;
	logic [DATA_W-1:0]        data_out;
	logic                     data_valid;
	logic                     empty_error;
	logic                     full_error;
	logic [OCC_W-1:0]         occupancy;
	int                       mismatches;
	int                       outstanding;

	int holds_asked;
	int holds_done;
	int burst_left;

	sorted_priority_queue DUT (.*);
	spq_checker checker_i (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#800000;
		$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

	// response side: stall pattern switches between random modes; long hold on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		rsp_stall  = 1'b0;
		holds_done = 0;
		mode       = RX_OPEN;
		mode_left  = 0;
		forever begin
			@(negedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   rsp_stall <= 1'b0;
					RX_LIGHT:  rsp_stall <= ($urandom_range(0, 99) < 30);
					RX_HEAVY:  rsp_stall <= ($urandom_range(0, 99) < 75);
					RX_TOGGLE: rsp_stall <= ~rsp_stall;
				endcase
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic offer_op(input cmd_t op, input logic [DATA_W-1:0] d,
		input logic signed [PRIO_W-1:0] p);
		req_valid   <= 1'b1;
		command     <= op;
		data_in     <= d;
		priority_in <= p;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// idle between bursts; with drain set, also wait until every response is back
	task automatic pace(input bit drain);
		if (burst_left == 0 || drain) begin
			req_valid <= 1'b0;
			if (burst_left == 0) begin
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				                                         : $urandom_range(1, 12);
			end
			while (drain && outstanding != 0) @(negedge clk);
		end
		burst_left--;
	endtask

	function automatic logic signed [PRIO_W-1:0] pick_prio();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return PRIO_W'($signed($urandom_range(0, 3)) - 2);
			4:          return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default:    return PRIO_W'($urandom);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int enq_pct;
		req_valid   = 1'b0;
		command     = CMD_ENQ;
		data_in     = '0;
		priority_in = '0;
		holds_asked = 0;
		burst_left  = 8;
		arst_n      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty dequeue, extreme priorities and ties, fill, full drop, drain a few
		offer_op(CMD_DEQ, '0, '0);
		offer_op(CMD_ENQ, 32'h0000_0000, 16'sh0000);
		offer_op(CMD_ENQ, 32'hffff_ffff, 16'sh7fff);
		offer_op(CMD_ENQ, 32'ha5a5_a5a5, 16'sh8000);
		offer_op(CMD_ENQ, 32'h0000_0001, -16'sd1);
		offer_op(CMD_ENQ, 32'h0000_0002, 16'sd1);
		offer_op(CMD_ENQ, 32'h0000_0003, 16'sh0000);
		offer_op(CMD_ENQ, 32'h0000_0004, 16'sh7fff);
		for (int i = 0; i < DEPTH - 7; i++)
			offer_op(CMD_ENQ, 32'h5a5a_0100 + i, PRIO_W'(i * 4000 - 16000));
		offer_op(CMD_ENQ, 32'hdead_0000, 16'sh7fff);
		repeat (4) offer_op(CMD_DEQ, '0, '0);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			// swing between filling, draining and balanced stretches to hit full and empty
			if (n % 40 == 0)
				case ($urandom_range(0, 2))
					0:       enq_pct = 80;
					1:       enq_pct = 20;
					default: enq_pct = 50;
				endcase
			if (n == 120)
				holds_asked++;
			pace(n == 250);
			offer_op(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
				pick_data(), pick_prio());
		end

		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** sorted_priority_queue: PASSED **");
		else
			$display("** sorted_priority_queue: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/tb_sorted_priority_queue.sv
